FILE: rtl/sem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared pixel types, queue entry format and fixed constants.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CHAN_W     = 8;
    localparam int N_CHAN     = 3;
    localparam int W_FIELD_W  = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [CHAN_W-1:0]   SAT_MAX    = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // one pixel, channel 0 at index 0
    typedef logic [N_CHAN-1:0][CHAN_W-1:0] t_pix;

    // classified item handed from the front to the back
    typedef struct packed {
        t_pix pix;
        t_pix up;
        t_pix mid;
        logic emit;
        logic interior;
        logic last;
    } t_work;

endpackage

FILE: rtl/sem_pix_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one RGB pixel and the drain flag.
// ----------------------------------------------------------------------------
interface sem_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::CHAN_W-1:0] chan0_in;
    logic [sem_pkg::CHAN_W-1:0] chan1_in;
    logic [sem_pkg::CHAN_W-1:0] chan2_in;
    logic                      drain;

    modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                    output drain, input ready);
    modport sink (input valid, input chan0_in, input chan1_in, input chan2_in,
                  input drain, output ready);
endinterface

FILE: rtl/sem_pix_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying one filtered pixel and the frame end flag.
// ----------------------------------------------------------------------------
interface sem_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::CHAN_W-1:0] chan0_out;
    logic [sem_pkg::CHAN_W-1:0] chan1_out;
    logic [sem_pkg::CHAN_W-1:0] chan2_out;
    logic                      frame_end;

    modport source (output valid, output chan0_out, output chan1_out, output chan2_out,
                    output frame_end, input ready);
    modport sink (input valid, input chan0_out, input chan1_out, input chan2_out,
                  input frame_end, output ready);
endinterface

FILE: rtl/sem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, tracks the frame position, reads and updates the two row
// stores and classifies each pixel before handing it to the queue.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sem_pix_in_if.sink                     i_pix,
    input  logic                           i_q_ready,
    output logic                           o_q_push,
    output sem_pkg::t_work                 o_q_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = XW + 1;
    localparam int CW    = (WW > sem_pkg::W_FIELD_W) ? WW : sem_pkg::W_FIELD_W;
    localparam int RST_W = (sem_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : sem_pkg::RESET_WIDTH;
    localparam int HW    = sem_pkg::HEIGHT_W;

    logic [WW-1:0] r_img_w, r_frame_w, n_img_w, fw;
    logic [HW-1:0] r_img_h, r_frame_h, n_img_h, fh;
    logic [XW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;

    logic          r_f1_valid;
    sem_pkg::t_pix r_f1_pix;
    logic [XW-1:0] r_f1_x;
    logic          r_f1_emit, r_f1_interior, r_f1_last;
    sem_pkg::t_pix r_up_rd, r_mid_rd;

    sem_pkg::t_pix mem_upper  [MAX_WIDTH];
    sem_pkg::t_pix mem_middle [MAX_WIDTH];

    logic [CW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;
    logic          idle, x0, emit, interior, last, wrap, ready, take;
    sem_pkg::t_pix pix;

    assign pix = {i_pix.chan2_in, i_pix.chan1_in, i_pix.chan0_in};

    // clamp configuration values into the supported range
    always_comb begin
        cfg_w = CW'(i_cfg_data[sem_pkg::W_FIELD_W-1:0]);
        if (cfg_w < CW'(sem_pkg::MIN_DIM)) begin
            cfg_w = CW'(sem_pkg::MIN_DIM);
        end else if (cfg_w > CW'(MAX_WIDTH)) begin
            cfg_w = CW'(MAX_WIDTH);
        end
        n_img_w = WW'(cfg_w);
        cfg_h = i_cfg_data[HW-1:0];
        if (cfg_h < HW'(sem_pkg::MIN_DIM)) begin
            cfg_h = HW'(sem_pkg::MIN_DIM);
        end else if (cfg_h > sem_pkg::MAX_HEIGHT) begin
            cfg_h = sem_pkg::MAX_HEIGHT;
        end
        n_img_h = cfg_h;
    end

    always_comb begin
        idle     = (r_col == '0) && (r_row == '0);
        fw       = idle ? r_img_w : r_frame_w;
        fh       = idle ? r_img_h : r_frame_h;
        x0       = (r_col == '0);
        emit     = (!x0 && r_row != '0) || (x0 && r_row >= HW'(2));
        interior = !x0 && (r_col >= XW'(2)) && (r_row >= HW'(2)) && (r_row < fh);
        last     = x0 && (r_row == fh + HW'(1));
        wrap     = (CNT_W'(r_col) + CNT_W'(1)) == CNT_W'(fw);
        ready    = !r_f1_valid || i_q_ready;
        take     = i_pix.valid && ready && !(idle && i_pix.drain);

        n_col = r_col;
        n_row = r_row;
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (wrap) begin
            n_col = '0;
            n_row = r_row + HW'(1);
        end else begin
            n_col = r_col + XW'(1);
        end
    end

    assign i_pix.ready = ready;
    assign o_q_push    = r_f1_valid && i_q_ready;
    assign o_q_data    = '{pix: r_f1_pix, up: r_up_rd, mid: r_mid_rd, emit: r_f1_emit,
                           interior: r_f1_interior, last: r_f1_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= WW'(RST_W);
            r_img_h    <= HW'(sem_pkg::RESET_HEIGHT);
            r_frame_w  <= WW'(RST_W);
            r_frame_h  <= HW'(sem_pkg::RESET_HEIGHT);
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sem_pkg::CFG_IMAGE_WIDTH:  r_img_w <= n_img_w;
                    sem_pkg::CFG_IMAGE_HEIGHT: r_img_h <= n_img_h;
                    default: ;
                endcase
            end
            if (take) begin
                if (idle) begin
                    r_frame_w <= r_img_w;
                    r_frame_h <= r_img_h;
                end
                r_col      <= n_col;
                r_row      <= n_row;
                r_f1_valid <= 1'b1;
            end else if (o_q_push) begin
                r_f1_valid <= 1'b0;
            end
        end
    end

    // item payload and middle row store: read old entry, write new pixel
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_f1_pix      <= pix;
            r_f1_x        <= r_col;
            r_f1_emit     <= emit;
            r_f1_interior <= interior;
            r_f1_last     <= last;
            r_mid_rd      <= mem_middle[r_col];
            mem_middle[r_col] <= pix;
        end
    end

    // upper row store: read on accept, retire the old middle entry on push
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_up_rd <= mem_upper[r_col];
        end
        if (o_q_push) begin
            mem_upper[r_f1_x] <= r_mid_rd;
        end
    end

endmodule

FILE: rtl/sem_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel work queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module sem_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sem_pkg::t_work i_data,
    output logic           o_ready,
    output logic           o_valid,
    output sem_pkg::t_work o_data,
    input  logic           i_pop
);

    localparam int DEPTH = 2;

    sem_pkg::t_work r_buf [DEPTH];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != 2'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/sem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel back end
// Shifts the 3x3 window per item and registers the clamped edge magnitude
// of interior pixels, or the centre pixel at the border, in the output register.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  sem_pkg::t_work i_q_data,
    output logic           o_q_pop,
    sem_pix_out_if.source  o_edge
);

    typedef logic [2:0][2:0][sem_pkg::CHAN_W-1:0] t_chwin;

    sem_pkg::t_pix r_win [3][3];
    logic          r_w_valid, r_w_interior, r_w_last;
    logic          r_o_valid, r_o_last;
    sem_pkg::t_pix r_o_pix, edge_pix;
    logic          o_adv, pop;
    t_chwin        chw [sem_pkg::N_CHAN];

    function automatic logic [sem_pkg::CHAN_W-1:0] sobel_mag(input t_chwin p);
        logic [9:0]  pos_y, neg_y, pos_x, neg_x, ay, ax;
        logic [7:0]  ay_s;
        logic [10:0] sum;
        pos_y = 10'(p[2][0]) + {1'b0, p[2][1], 1'b0} + 10'(p[2][2]);
        neg_y = 10'(p[0][0]) + {1'b0, p[0][1], 1'b0} + 10'(p[0][2]);
        pos_x = 10'(p[0][2]) + {1'b0, p[1][2], 1'b0} + 10'(p[2][2]);
        neg_x = 10'(p[0][0]) + {1'b0, p[1][0], 1'b0} + 10'(p[2][0]);
        ay    = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
        ax    = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
        ay_s  = (ay > 10'(sem_pkg::SAT_MAX)) ? sem_pkg::SAT_MAX : ay[7:0];
        sum   = 11'(ay_s) + 11'(ax);
        return (sum > 11'(sem_pkg::SAT_MAX)) ? sem_pkg::SAT_MAX : sum[7:0];
    endfunction

    always_comb begin
        for (int ch = 0; ch < sem_pkg::N_CHAN; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    chw[ch][r][c] = r_win[r][c][ch];
                end
            end
            edge_pix[ch] = sobel_mag(chw[ch]);
        end
    end

    assign o_adv   = r_w_valid && (!r_o_valid || o_edge.ready);
    assign pop     = i_q_valid && (!r_w_valid || o_adv);
    assign o_q_pop = pop;

    assign o_edge.valid     = r_o_valid;
    assign o_edge.chan0_out = r_o_pix[0];
    assign o_edge.chan1_out = r_o_pix[1];
    assign o_edge.chan2_out = r_o_pix[2];
    assign o_edge.frame_end = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_w_valid <= i_q_data.emit;
            end else if (o_adv) begin
                r_w_valid <= 1'b0;
            end
            if (o_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_edge.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // window shift per item, result capture per emitted item
    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2]  <= i_q_data.up;
            r_win[1][2]  <= i_q_data.mid;
            r_win[2][2]  <= i_q_data.pix;
            r_w_interior <= i_q_data.interior;
            r_w_last     <= i_q_data.last;
        end
        if (o_adv) begin
            r_o_pix  <= r_w_interior ? edge_pix : r_win[1][1];
            r_o_last <= r_w_last;
        end
    end

endmodule

FILE: rtl/sobel_edge_magnitude_rgb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit, RGB
// Streaming 3x3 Sobel filter with saturated |Gy| + |Gx| per channel.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes raster-order pixels of one frame; a transaction carries three
//   8-bit channels and a drain flag. After the last pixel, send width+1 drain
//   transactions to flush the tail; a drain with no frame open is dropped.
//   o_edge gives one pixel per transaction, one row plus one pixel behind the
//   input; border pixels pass through, interior pixels get
//   min(255, min(255,|Gy|) + |Gx|). frame_end marks the last pixel of a frame.
//   The user writes width and height over the cfg port while the unit is
//   idle (not enforced); values, clamped, take effect at the next frame start.
// Throughput and pipeline:
//   One transaction per cycle in both directions while o_edge is not stalled.
//   The transaction that completes a window passes the accept register with
//   row store read, the queue, the window shift stage and the output register.
// Reset and stalls:
//   Reset clears the frame position, pipeline valid flags and restores the
//   default 640x480 size; row stores are not cleared. When o_edge stalls, the
//   output register holds, the back end stops, the two-entry queue fills and
//   then i_pix.ready drops.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sem_pix_in_if.sink                     i_pix,
    sem_pix_out_if.source                  o_edge
);

    // front to queue
    logic           push, q_ready;
    sem_pkg::t_work push_data;

    // queue to back
    logic           q_valid, q_pop;
    sem_pkg::t_work q_data;

    // classify each pixel and keep the row stores up to date
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_ready  (q_ready),
        .o_q_push   (push),
        .o_q_data   (push_data)
    );

    // decouple front and back so each can stall on its own
    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // shift the window and produce the filtered pixel
    sem_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_edge    (o_edge)
    );

endmodule

FILE: tb/sv/sobel_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge result checker
// Watches the config port and both pixel channels, keeps its own line
// buffers and 3x3 window, works out the filtered pixel that each accepted
// input transaction releases and compares each accepted output against it.
// ----------------------------------------------------------------------------
module sobel_result_check #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sem_pix_in_if                          i_pix,
    sem_pix_out_if                         i_edge,
    output int                             o_fail_count,
    output int                             o_pending,
    output logic                           o_frame_open
);
    import sem_pkg::*;

    typedef struct packed {
        t_pix pix;
        logic frame_end;
    } edge_result_t;

    t_pix         upper_row [MAX_WIDTH];
    t_pix         middle_row [MAX_WIDTH];
    t_pix         win [3][3];
    int unsigned  col_pos, row_pos;
    int unsigned  frame_w, frame_h;
    int unsigned  width_reg, height_reg;
    edge_result_t edge_q [$];
    int           fails = 0;

    // saturated |Gy| plus |Gx| for one channel of the current window
    function automatic logic [CHAN_W-1:0] edge_strength(input int ch);
        int p [3][3];
        int gy, gx, ay, ax, sum;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p[r][c] = int'(win[r][c][ch]);
            end
        end
        gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        ay = (gy < 0) ? -gy : gy;
        ax = (gx < 0) ? -gx : gx;
        if (ay > int'(SAT_MAX)) ay = int'(SAT_MAX);
        sum = ay + ax;
        if (sum > int'(SAT_MAX)) sum = int'(SAT_MAX);
        return CHAN_W'(sum);
    endfunction

    // advance the frame position by one pixel and queue the result it releases
    task automatic advance_window(input t_pix pix, input logic drain);
        int unsigned  x, y, cx, cy;
        t_pix         up, mid;
        logic         emit, last, interior;
        edge_result_t res;
        if (row_pos == 0 && col_pos == 0) begin
            // drop a drain with no frame open, latch the size otherwise
            if (drain) return;
            frame_w = width_reg;
            frame_h = height_reg;
        end
        x = col_pos;
        y = row_pos;
        up  = upper_row[x];
        mid = middle_row[x];
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;
        upper_row[x]  = mid;
        middle_row[x] = pix;

        emit = 1'b0;
        last = 1'b0;
        cx   = 0;
        cy   = 0;
        if (x >= 1 && y >= 1) begin
            emit = 1'b1;
            cx   = x - 1;
            cy   = y - 1;
        end else if (x == 0 && y >= 2) begin
            emit = 1'b1;
            cx   = frame_w - 1;
            cy   = y - 2;
        end
        if (emit) begin
            interior = (cy >= 1) && (cy + 2 <= frame_h) && (cx >= 1) && (cx + 2 <= frame_w);
            last     = (cy + 1 == frame_h) && (cx + 1 == frame_w);
            for (int ch = 0; ch < N_CHAN; ch++) begin
                res.pix[ch] = interior ? edge_strength(ch) : win[1][1][ch];
            end
            res.frame_end = last;
            edge_q.push_back(res);
        end

        col_pos++;
        if (col_pos >= frame_w) begin
            col_pos = 0;
            row_pos++;
        end
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin
        edge_result_t want;
        t_pix         got;
        int unsigned  v;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win[r][c] = '0;
                end
            end
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            frame_w    = RESET_WIDTH;
            frame_h    = RESET_HEIGHT;
            edge_q.delete();
        end else begin
            if (i_edge.valid && i_edge.ready) begin
                got = {i_edge.chan2_out, i_edge.chan1_out, i_edge.chan0_out};
                if (edge_q.size() == 0) begin
                    $error("unexpected output transaction: chan0_out %0d chan1_out %0d chan2_out %0d",
                           got[0], got[1], got[2]);
                    fails++;
                end else begin
                    want = edge_q.pop_front();
                    for (int ch = 0; ch < N_CHAN; ch++) begin
                        if (got[ch] !== want.pix[ch]) begin
                            $error("chan%0d_out: expected %0d, actual %0d",
                                   ch, want.pix[ch], got[ch]);
                            fails++;
                        end
                    end
                    if (i_edge.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, i_edge.frame_end);
                        fails++;
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                advance_window({i_pix.chan2_in, i_pix.chan1_in, i_pix.chan0_in}, i_pix.drain);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                    v = int'(i_cfg_data[W_FIELD_W-1:0]);
                    if (v < MIN_DIM) v = MIN_DIM;
                    if (v > MAX_WIDTH) v = MAX_WIDTH;
                    width_reg = v;
                end else if (i_cfg_idx == CFG_IMAGE_HEIGHT) begin
                    v = int'(i_cfg_data);
                    if (v < MIN_DIM) v = MIN_DIM;
                    if (v > int'(MAX_HEIGHT)) v = int'(MAX_HEIGHT);
                    height_reg = v;
                end
            end
        end
        o_pending    <= edge_q.size();
        o_fail_count <= fails;
        o_frame_open <= (row_pos != 0) || (col_pos != 0);
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit testbench
// Drives raster frames of RGB pixels with drain flushes through the unit
// under several frame sizes, with random gaps on both channels and one long
// output hold-off; the result checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import sem_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 16;    // pipeline depth is four, give margin
    localparam int HOLD_CYCLES    = 600;   // long output hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // several times the longest quiet stretch
    localparam int RANDOM_ITEMS   = 900;
    localparam int HOLD_W         = 48;    // frame size used for the hold-off
    localparam int HOLD_H         = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sem_pix_in_if  pix_if ();
    sem_pix_out_if edge_if ();

    int   fail_count;
    int   pending;
    logic frame_open;

    // stimulus side bookkeeping
    int eff_w = RESET_WIDTH;
    int eff_h = RESET_HEIGHT;
    int random_items = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;   // ask the output side for one long hold-off
    bit steady_in = 1'b0;  // no input gaps for the current frame

    sobel_edge_magnitude_rgb_unit #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_edge     (edge_if)
    );

    sobel_result_check #(
        .MAX_WIDTH (MAX_W)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_if),
        .i_edge       (edge_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frame_open (frame_open)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one pixel transaction and hold it until the unit takes it.
    // Called right after a rising edge; returns at the accepting edge.
    task automatic push_pixel(input t_pix p, input logic drain);
        int gap;
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.chan0_in <= p[0];
        pix_if.chan1_in <= p[1];
        pix_if.chan2_in <= p[2];
        pix_if.drain    <= drain;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Drop valid and wait until every expected result has left the unit,
    // then let the pipeline run dry before touching the registers.
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write width and/or height in back-to-back cycles; track the clamped size.
    task automatic program_size(input bit wr_w, input logic [CFG_DATA_W-1:0] w,
                                input bit wr_h, input logic [CFG_DATA_W-1:0] h);
        int v;
        if (wr_w) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IMAGE_WIDTH;
            cfg_data <= w;
            @(posedge i_clk);
            v = int'(w[W_FIELD_W-1:0]);
            eff_w = (v < MIN_DIM) ? MIN_DIM : (v > MAX_W) ? MAX_W : v;
        end
        if (wr_h) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IMAGE_HEIGHT;
            cfg_data <= h;
            @(posedge i_clk);
            v = int'(h);
            eff_h = (v < MIN_DIM) ? MIN_DIM : (v > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : v;
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send n raster pixels of a w-wide frame, then a number of drains.
    // Content is picked per call: full random, black/white, or ramps of small
    // random steps plus noise.
    task automatic send_pixels(input int w, input int n, input int drains);
        int          style, r, c;
        int unsigned base [N_CHAN];
        int unsigned dx [N_CHAN];
        int unsigned dy [N_CHAN];
        t_pix        p;
        style     = $urandom_range(0, 2);
        steady_in = ($urandom_range(0, 3) == 0);
        for (int ch = 0; ch < N_CHAN; ch++) begin
            base[ch] = $urandom_range(0, 255);
            dx[ch]   = $urandom_range(0, 15);
            dy[ch]   = $urandom_range(0, 15);
        end
        for (int i = 0; i < n; i++) begin
            r = i / w;
            c = i % w;
            for (int ch = 0; ch < N_CHAN; ch++) begin
                case (style)
                    0: p[ch] = CHAN_W'($urandom);
                    1: p[ch] = ($urandom_range(0, 1) != 0) ? SAT_MAX : '0;
                    default: p[ch] = CHAN_W'(base[ch] + r * dy[ch] + c * dx[ch] +
                                             $urandom_range(0, 3));
                endcase
            end
            // now and then a drain flag inside the frame; never on the first
            // pixel, where it would be dropped and shift the whole frame
            push_pixel(p, (i != 0) && ($urandom_range(0, 29) == 0));
        end
        for (int i = 0; i < drains; i++) begin
            push_pixel(t_pix'($urandom), 1'b1);
        end
        steady_in = 1'b0;
    endtask

    // Flush with drains until the checker sees no open frame.
    task automatic close_frame();
        while (frame_open) push_pixel(t_pix'($urandom), 1'b1);
    endtask

    // One random phase: new size, a few frames, some of them broken.
    task automatic random_phase();
        int w, h, wsel, frames, kind, n;
        w    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
        h    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(3, 8);
        wsel = $urandom_range(0, 3);
        program_size(wsel != 2, CFG_DATA_W'(w), wsel != 1, CFG_DATA_W'(h));
        frames = $urandom_range(1, 4);
        for (int f = 0; f < frames; f++) begin
            kind = $urandom_range(0, 9);
            n    = eff_w * eff_h;
            case (kind)
                7: begin
                    // stray drains ahead of the frame
                    repeat ($urandom_range(1, 3)) push_pixel(t_pix'($urandom), 1'b1);
                    send_pixels(eff_w, n, eff_w + 1);
                end
                8: send_pixels(eff_w, n, $urandom_range(0, eff_w));  // short flush
                9: begin
                    n = n - $urandom_range(1, eff_w);                // short frame
                    send_pixels(eff_w, n, eff_w + 1);
                end
                default: send_pixels(eff_w, n, eff_w + 1 + $urandom_range(0, 2));
            endcase
            random_items += n;
        end
        close_frame();
        settle();
    endtask

    // Output side: ready with random stalls, one long hold-off on request.
    initial begin
        int run, gap;
        edge_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        edge_if.ready <= 1'b1;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                edge_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                edge_if.ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    edge_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    edge_if.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main stimulus
    initial begin
        t_pix p;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_IMAGE_WIDTH;
        cfg_data        <= '0;
        pix_if.valid    <= 1'b0;
        pix_if.chan0_in <= '0;
        pix_if.chan1_in <= '0;
        pix_if.chan2_in <= '0;
        pix_if.drain    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sizes below the minimum clamp to 3x3.
        program_size(1'b1, CFG_DATA_W'(0), 1'b1, CFG_DATA_W'(2));

        // Drains with no frame open are dropped.
        push_pixel(t_pix'($urandom), 1'b1);
        push_pixel(t_pix'($urandom), 1'b1);

        // Frame with a large negative Gy on channel 0, a large positive Gy on
        // channel 1 and a moderate ramp on channel 2 that stays unsaturated.
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p[0] = (r == 0) ? SAT_MAX : (r == 2) ? 8'd0 : 8'd128;
                p[1] = (r == 0) ? 8'd0 : (r == 2) ? SAT_MAX : 8'd77;
                p[2] = CHAN_W'(10 + 15 * c + r);
                push_pixel(p, 1'b0);
            end
        end
        repeat (4) push_pixel(t_pix'($urandom), 1'b1);

        // Black/white frame whose centre pixel carries the drain flag inside
        // the frame and must be filtered as an ordinary pixel.
        for (int i = 0; i < 9; i++) begin
            for (int ch = 0; ch < N_CHAN; ch++) begin
                p[ch] = ($urandom_range(0, 1) != 0) ? SAT_MAX : '0;
            end
            if (i == 4) begin
                push_pixel({N_CHAN{SAT_MAX}}, 1'b1);
            end else begin
                push_pixel(p, 1'b0);
            end
        end
        repeat (4) push_pixel(t_pix'($urandom), 1'b1);
        settle();

        // Write during a frame: the new size waits for the next frame start.
        // Width data with bits above the field set must mask down to 5.
        program_size(1'b1, CFG_DATA_W'(13'h1805), 1'b1, CFG_DATA_W'(4));
        send_pixels(5, 10, 0);
        settle();
        program_size(1'b1, CFG_DATA_W'(7), 1'b1, CFG_DATA_W'(3));
        send_pixels(5, 10, 6);
        close_frame();
        settle();
        send_pixels(7, 21, 8);
        close_frame();
        settle();

        // Medium frame, with the long output hold-off while pixels keep coming.
        program_size(1'b1, CFG_DATA_W'(HOLD_W), 1'b1, CFG_DATA_W'(HOLD_H));
        hold_req = 1'b1;
        send_pixels(eff_w, eff_w * eff_h, eff_w + 1);
        close_frame();
        settle();

        // Random phases of small frames, well-formed and broken.
        while (random_items < RANDOM_ITEMS) random_phase();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
